>>> hdl/cfl_timestep_limiter_defines.svh
// Assertion macros for the CFL time step limiter.
`ifndef CFL_TIMESTEP_LIMITER_DEFINES_SVH
`define CFL_TIMESTEP_LIMITER_DEFINES_SVH
`ifndef ASSERT_OFF
`define CFL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CFL_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CFL_ASSERT(lbl, prop, msg)
`define CFL_ASSERT_NR(lbl, prop, msg)
`endif
`endif

>>> hdl/cfl_pkg.sv
// Shared types and constants of the CFL time step limiter.
package cfl_pkg;

  localparam int VEL_W  = 48;
  localparam int SPC_W  = 32;
  localparam int RE_W   = 32;
  localparam int CFL_W  = 18;
  localparam int STEP_W = 23;
  localparam int LIM_W  = 41;
  localparam int ALU_W  = 96;
  localparam int OPD_W  = 64;
  localparam int CNT_W  = 7;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [LIM_W-1:0]  LIMIT_CAP   = 41'h100_0000_0000;
  localparam logic [LIM_W-1:0]  LIM_FLOOR   = 41'd4295;
  localparam logic [STEP_W-1:0] DT_FLOOR    = 23'd4295;
  localparam logic [STEP_W-1:0] DT_CEIL     = 23'd4294967;
  localparam logic [OPD_W-1:0]  VEL_QUALIFY = 64'd65536000000;

  localparam logic [CNT_W-1:0] SQ_STEPS  = 7'd32;
  localparam logic [CNT_W-1:0] RE_STEPS  = 7'd32;
  localparam logic [CNT_W-1:0] DIV_STEPS = 7'd64;
  localparam logic [CNT_W-1:0] CFL_STEPS = 7'd18;

  typedef enum logic [1:0] {
    REG_SPACING_X,
    REG_SPACING_Y,
    REG_REYNOLDS,
    REG_SAFETY_FACTOR
  } reg_idx_t;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef enum logic [3:0] {
    C_IDLE,
    C_SQ,
    C_SQ_W,
    C_RE,
    C_RE_W,
    C_DU,
    C_DU_W,
    C_DV,
    C_DV_W,
    C_SCALE,
    C_SCALE_W,
    C_OUT
  } ctl_state_t;

  typedef struct packed {
    logic             start;
    alu_op_t          op;
    logic [CNT_W-1:0] steps;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

  typedef struct packed {
    logic [SPC_W-1:0] spacing_x;
    logic [SPC_W-1:0] spacing_y;
    logic [RE_W-1:0]  reynolds;
    logic [CFL_W-1:0] safety_factor;
  } cfg_t;

  typedef struct packed {
    logic                    kind;
    logic signed [VEL_W-1:0] velocity;
    logic                    last;
  } in_word_t;

  typedef struct packed {
    logic [STEP_W-1:0] time_step;
    logic [VEL_W-1:0]  max_abs_u;
    logic [VEL_W-1:0]  max_abs_v;
  } out_word_t;

endpackage

>>> hdl/cfl_regs.sv
// Configuration register file with an APB-style access port.
module cfl_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cfl_pkg::ADDR_W-1:0]   paddr,
  input  logic [cfl_pkg::DATA_W-1:0]   pwdata,
  output logic [cfl_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output cfl_pkg::cfg_t                cfg
);

  cfl_pkg::cfg_t      cfg_r;
  cfl_pkg::reg_idx_t  idx;
  logic               wr_en;

  assign idx    = cfl_pkg::reg_idx_t'(paddr[cfl_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spacing_x     <= 32'd512;
      cfg_r.spacing_y     <= 32'd512;
      cfg_r.reynolds      <= 32'd25600;
      cfg_r.safety_factor <= 18'd32768;
    end else if (wr_en) begin
      unique case (idx)
        cfl_pkg::REG_SPACING_X:     cfg_r.spacing_x <= pwdata;
        cfl_pkg::REG_SPACING_Y:     cfg_r.spacing_y <= pwdata;
        cfl_pkg::REG_REYNOLDS:      cfg_r.reynolds  <= pwdata;
        cfl_pkg::REG_SAFETY_FACTOR: cfg_r.safety_factor <= pwdata[cfl_pkg::CFL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      cfl_pkg::REG_SPACING_X:     prdata = cfg_r.spacing_x;
      cfl_pkg::REG_SPACING_Y:     prdata = cfg_r.spacing_y;
      cfl_pkg::REG_REYNOLDS:      prdata = cfg_r.reynolds;
      cfl_pkg::REG_SAFETY_FACTOR: prdata = {{(cfl_pkg::DATA_W-cfl_pkg::CFL_W){1'b0}},
                                            cfg_r.safety_factor};
      default:                    prdata = '0;
    endcase
  end

endmodule

>>> hdl/cfl_alu.sv
// Shared bit-serial shift-add multiplier and restoring divider around one adder.
module cfl_alu (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cfl_pkg::alu_req_t           req,
  input  logic [cfl_pkg::OPD_W-1:0]   opnd_a,
  input  logic [cfl_pkg::OPD_W-1:0]   opnd_b,
  output cfl_pkg::alu_stat_t          stat,
  output logic [cfl_pkg::ALU_W-1:0]   result
);

  localparam int AW = cfl_pkg::ALU_W;
  localparam int BW = cfl_pkg::OPD_W;

  logic                       busy_r;
  logic                       done_r;
  logic [cfl_pkg::CNT_W-1:0]  cnt_r;
  cfl_pkg::alu_op_t           op_r;
  logic [AW-1:0]              acc_r;
  logic [AW-1:0]              opa_r;
  logic [BW-1:0]              opb_r;

  logic                       is_div;
  logic [AW-1:0]              shifted;
  logic [AW-1:0]              add_x;
  logic [AW-1:0]              add_y;
  logic [AW:0]                sum;
  logic                       carry;

  // In divide mode the adder subtracts the divisor from the shifted remainder.
  assign is_div  = (op_r == cfl_pkg::ALU_DIV);
  assign shifted = {acc_r[AW-2:0], opb_r[BW-1]};
  assign add_x   = is_div ? shifted : acc_r;
  assign add_y   = is_div ? ~opa_r : opa_r;
  assign sum     = {1'b0, add_x} + {1'b0, add_y} + {{AW{1'b0}}, is_div};
  assign carry   = sum[AW];

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign result    = is_div ? {{(AW-BW){1'b0}}, opb_r} : acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= cfl_pkg::ALU_MUL;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
        op_r   <= req.op;
      end else if (busy_r) begin
        cnt_r <= cnt_r - cfl_pkg::CNT_W'(1);
        if (cnt_r == cfl_pkg::CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      acc_r <= '0;
      opa_r <= {{(AW-BW){1'b0}}, opnd_a};
      opb_r <= opnd_b;
    end else if (busy_r) begin
      if (is_div) begin
        acc_r <= carry ? sum[AW-1:0] : shifted;
        opb_r <= {opb_r[BW-2:0], carry};
      end else begin
        if (opb_r[0]) begin
          acc_r <= sum[AW-1:0];
        end
        opa_r <= {opa_r[AW-2:0], 1'b0};
        opb_r <= {1'b0, opb_r[BW-1:1]};
      end
    end
  end

endmodule

>>> hdl/cfl_ctrl.sv
// Peak tracking, step sequencer and result register of the CFL time step limiter.
module cfl_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cfl_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  cfl_pkg::in_word_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cfl_pkg::out_word_t          out_data,
  output cfl_pkg::alu_req_t           alu_req,
  output logic [cfl_pkg::OPD_W-1:0]   alu_a,
  output logic [cfl_pkg::OPD_W-1:0]   alu_b,
  input  cfl_pkg::alu_stat_t          alu_stat,
  input  logic [cfl_pkg::ALU_W-1:0]   alu_res
);

  localparam int VW = cfl_pkg::VEL_W;
  localparam int LW = cfl_pkg::LIM_W;
  localparam int OW = cfl_pkg::OPD_W;
  localparam int SW = cfl_pkg::STEP_W;

  cfl_pkg::ctl_state_t  state_r;
  cfl_pkg::ctl_state_t  state_nxt;
  logic [VW-1:0]        peak_u_r;
  logic [VW-1:0]        peak_v_r;
  logic [VW-1:0]        snap_u_r;
  logic [VW-1:0]        snap_v_r;
  logic [LW-1:0]        diff_r;
  logic [LW-1:0]        adv_r;
  logic                 have_r;
  logic                 out_valid_r;
  cfl_pkg::out_word_t   out_data_r;

  logic                 accept;
  logic                 out_free;
  logic [VW-1:0]        vel_bits;
  logic [VW-1:0]        mag;
  logic [VW-1:0]        new_u;
  logic [VW-1:0]        new_v;
  logic                 qual_u;
  logic                 qual_v;
  logic                 re_zero;
  logic [cfl_pkg::SPC_W-1:0] min_spc;
  logic [OW-1:0]        quot;
  logic [LW-1:0]        quot_sat;
  logic [LW-1:0]        diff_mul;
  logic [LW-1:0]        adv_min;
  logic [LW-1:0]        base;
  logic [SW+19:0]       scaled;
  logic [SW-1:0]        step;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == cfl_pkg::C_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign vel_bits = in_data.velocity;
  assign mag      = vel_bits[VW-1] ? (~vel_bits + VW'(1)) : vel_bits;
  assign new_u    = (!in_data.kind && (mag > peak_u_r)) ? mag : peak_u_r;
  assign new_v    = (in_data.kind && (mag > peak_v_r)) ? mag : peak_v_r;

  assign qual_u  = (snap_u_r != '0) &&
                   ({{(OW-VW){1'b0}}, snap_u_r} < cfl_pkg::VEL_QUALIFY);
  assign qual_v  = (snap_v_r != '0) &&
                   ({{(OW-VW){1'b0}}, snap_v_r} < cfl_pkg::VEL_QUALIFY);
  assign re_zero = (cfg.reynolds == '0);
  assign min_spc = (cfg.spacing_x < cfg.spacing_y) ? cfg.spacing_x : cfg.spacing_y;

  assign quot     = alu_res[OW-1:0];
  assign quot_sat = (quot > {{(OW-LW){1'b0}}, cfl_pkg::LIMIT_CAP}) ?
                    cfl_pkg::LIMIT_CAP : quot[LW-1:0];
  assign diff_mul = (|alu_res[cfl_pkg::ALU_W-1:49]) ?
                    cfl_pkg::LIMIT_CAP : {1'b0, alu_res[48:9]};

  assign adv_min = (have_r && (adv_r < diff_r)) ? adv_r : diff_r;
  assign base    = (adv_min < cfl_pkg::LIM_FLOOR) ? cfl_pkg::LIM_FLOOR : adv_min;

  assign scaled = alu_res[58:16];
  always_comb begin
    priority if (scaled < {{20{1'b0}}, cfl_pkg::DT_FLOOR}) begin
      step = cfl_pkg::DT_FLOOR;
    end else if (scaled > {{20{1'b0}}, cfl_pkg::DT_CEIL}) begin
      step = cfl_pkg::DT_CEIL;
    end else begin
      step = scaled[SW-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cfl_pkg::C_IDLE:    if (accept && in_data.last) state_nxt = cfl_pkg::C_SQ;
      cfl_pkg::C_SQ:      state_nxt = cfl_pkg::C_SQ_W;
      cfl_pkg::C_SQ_W:    if (alu_stat.done) state_nxt = cfl_pkg::C_RE;
      cfl_pkg::C_RE:      state_nxt = re_zero ? cfl_pkg::C_DU : cfl_pkg::C_RE_W;
      cfl_pkg::C_RE_W:    if (alu_stat.done) state_nxt = cfl_pkg::C_DU;
      cfl_pkg::C_DU:      state_nxt = qual_u ? cfl_pkg::C_DU_W : cfl_pkg::C_DV;
      cfl_pkg::C_DU_W:    if (alu_stat.done) state_nxt = cfl_pkg::C_DV;
      cfl_pkg::C_DV:      state_nxt = qual_v ? cfl_pkg::C_DV_W : cfl_pkg::C_SCALE;
      cfl_pkg::C_DV_W:    if (alu_stat.done) state_nxt = cfl_pkg::C_SCALE;
      cfl_pkg::C_SCALE:   state_nxt = cfl_pkg::C_SCALE_W;
      cfl_pkg::C_SCALE_W: if (alu_stat.done) state_nxt = cfl_pkg::C_OUT;
      cfl_pkg::C_OUT:     if (out_free) state_nxt = cfl_pkg::C_IDLE;
      default:            state_nxt = cfl_pkg::C_IDLE;
    endcase
  end

  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op    = cfl_pkg::ALU_MUL;
    alu_req.steps = cfl_pkg::SQ_STEPS;
    alu_a         = {{(OW-cfl_pkg::SPC_W){1'b0}}, min_spc};
    alu_b         = {{(OW-cfl_pkg::SPC_W){1'b0}}, min_spc};
    unique case (state_r)
      cfl_pkg::C_SQ: begin
        alu_req.start = 1'b1;
      end
      cfl_pkg::C_RE: begin
        alu_req.start = !re_zero;
        alu_req.steps = cfl_pkg::RE_STEPS;
        alu_a         = alu_res[OW-1:0];
        alu_b         = {{(OW-cfl_pkg::RE_W){1'b0}}, cfg.reynolds};
      end
      cfl_pkg::C_DU: begin
        alu_req.start = qual_u;
        alu_req.op    = cfl_pkg::ALU_DIV;
        alu_req.steps = cfl_pkg::DIV_STEPS;
        alu_a         = {{(OW-VW){1'b0}}, snap_u_r};
        alu_b         = {cfg.spacing_x, {(OW-cfl_pkg::SPC_W){1'b0}}};
      end
      cfl_pkg::C_DV: begin
        alu_req.start = qual_v;
        alu_req.op    = cfl_pkg::ALU_DIV;
        alu_req.steps = cfl_pkg::DIV_STEPS;
        alu_a         = {{(OW-VW){1'b0}}, snap_v_r};
        alu_b         = {cfg.spacing_y, {(OW-cfl_pkg::SPC_W){1'b0}}};
      end
      cfl_pkg::C_SCALE: begin
        alu_req.start = 1'b1;
        alu_req.steps = cfl_pkg::CFL_STEPS;
        alu_a         = {{(OW-LW){1'b0}}, base};
        alu_b         = {{(OW-cfl_pkg::CFL_W){1'b0}}, cfg.safety_factor};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfl_pkg::C_IDLE;
      peak_u_r    <= '0;
      peak_v_r    <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        if (in_data.last) begin
          peak_u_r <= '0;
          peak_v_r <= '0;
          have_r   <= 1'b0;
        end else begin
          peak_u_r <= new_u;
          peak_v_r <= new_v;
        end
      end
      if ((state_r == cfl_pkg::C_DU_W) && alu_stat.done) begin
        have_r <= 1'b1;
      end
      if ((state_r == cfl_pkg::C_DV_W) && alu_stat.done) begin
        have_r <= 1'b1;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == cfl_pkg::C_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.last) begin
      snap_u_r <= new_u;
      snap_v_r <= new_v;
    end
    if ((state_r == cfl_pkg::C_RE) && re_zero) begin
      diff_r <= '0;
    end
    if ((state_r == cfl_pkg::C_RE_W) && alu_stat.done) begin
      diff_r <= diff_mul;
    end
    if ((state_r == cfl_pkg::C_DU_W) && alu_stat.done) begin
      adv_r <= quot_sat;
    end
    if ((state_r == cfl_pkg::C_DV_W) && alu_stat.done) begin
      if (!have_r || (quot_sat < adv_r)) begin
        adv_r <= quot_sat;
      end
    end
    if ((state_r == cfl_pkg::C_OUT) && out_free) begin
      out_data_r.time_step <= step;
      out_data_r.max_abs_u <= snap_u_r;
      out_data_r.max_abs_v <= snap_v_r;
    end
  end

endmodule

>>> hdl/cfl_timestep_limiter.sv
// Top level of the CFL time step limiter.
// A word that is not marked last only updates the peak magnitudes, and such
// words can arrive in every cycle while the block is ready. A word marked last
// starts the step calculation and the block is not ready until it is finished.
// The calculation runs on the single shared shift-add/subtract unit, which
// handles one bit per cycle, in order: the squared spacing, the Reynolds
// product unless the Reynolds number is zero, a division by each qualifying
// peak velocity and the CFL scaling. The block also stays not ready while the
// previous result word still waits to be taken. The result word waits in an
// output register, so the next run can start while it is still pending.
`include "cfl_timestep_limiter_defines.svh"

module cfl_timestep_limiter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  cfl_pkg::in_word_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cfl_pkg::out_word_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cfl_pkg::ADDR_W-1:0]  paddr,
  input  logic [cfl_pkg::DATA_W-1:0]  pwdata,
  output logic [cfl_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  cfl_pkg::cfg_t                cfg;
  cfl_pkg::alu_req_t            alu_req;
  cfl_pkg::alu_stat_t           alu_stat;
  logic [cfl_pkg::OPD_W-1:0]    alu_a;
  logic [cfl_pkg::OPD_W-1:0]    alu_b;
  logic [cfl_pkg::ALU_W-1:0]    alu_res;

  cfl_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cfl_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .opnd_a (alu_a),
    .opnd_b (alu_b),
    .stat   (alu_stat),
    .result (alu_res)
  );

  cfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .alu_req   (alu_req),
    .alu_a     (alu_a),
    .alu_b     (alu_b),
    .alu_stat  (alu_stat),
    .alu_res   (alu_res)
  );

  `CFL_ASSERT(a_last_stalls, in_valid && in_ready && in_data.last |=> !in_ready, "last word did not stall input")
  `CFL_ASSERT(a_alu_busy_stall, alu_stat.busy |-> !in_ready, "input ready while unit busy")
  `CFL_ASSERT(a_step_range, out_valid |-> (out_data.time_step >= cfl_pkg::DT_FLOOR) && (out_data.time_step <= cfl_pkg::DT_CEIL), "time step out of range")
  `CFL_ASSERT_NR(a_reset_clears, !rst_n |=> !out_valid, "result valid after reset")

endmodule

>>> verif/testbench.sv
// Self-checking testbench of the CFL time step limiter: directed table, then random runs.
module testbench;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    cfl_pkg::reg_idx_t    idx;
    logic [31:0]          value;
    cfl_pkg::in_word_t    word;
    bit                   typed;
    cfl_pkg::out_word_t   want;
  } plan_row_t;

  localparam logic [63:0] STEP_MIN    = 64'd4295;
  localparam logic [63:0] STEP_MAX    = 64'd4294967;
  localparam logic [63:0] LIM_MAX     = 64'h100_0000_0000;
  localparam logic [63:0] QUALIFY_MAX = 64'd65536000000;
  localparam int SETTLE_CYCLES = 240;
  localparam int STALL_LIMIT   = 5000;
  localparam int PHASES        = 8;
  localparam int PHASE_WORDS   = 155;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  cfl_pkg::in_word_t             in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  cfl_pkg::out_word_t            out_data;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [cfl_pkg::ADDR_W-1:0]    paddr = '0;
  logic [cfl_pkg::DATA_W-1:0]    pwdata = '0;
  logic [cfl_pkg::DATA_W-1:0]    prdata;
  logic                          pready;

  logic [31:0] dx_cfg = 32'd512;
  logic [31:0] dy_cfg = 32'd512;
  logic [31:0] re_cfg = 32'd25600;
  logic [17:0] cfl_cfg = 18'd32768;
  logic [63:0] peak_u = '0;
  logic [63:0] peak_v = '0;

  cfl_pkg::out_word_t  pending_steps[$];
  cfl_pkg::out_word_t  head;
  plan_row_t           plan[$];
  idle_mode_t          idle_mode = IDLE_NONE;
  int                  mismatches = 0;
  int                  words_sent = 0;
  int                  steps_checked = 0;
  int                  quiet_cycles = 0;

  cfl_timestep_limiter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void note_mismatch(string what, logic [63:0] want_v, logic [63:0] got_v);
    mismatches++;
    if (mismatches <= 10) $display("mismatch on %s: expected %0d, got %0d", what, want_v, got_v);
  endfunction

  function automatic logic [22:0] predict_step(logic [63:0] pu, logic [63:0] pv);
    logic [127:0] prod;
    logic [63:0]  d_min, diffusive, advective, cand, base, scaled;
    bit           have_adv;
    d_min = (dx_cfg < dy_cfg) ? 64'(dx_cfg) : 64'(dy_cfg);
    prod = (128'(d_min) * 128'(d_min) * 128'(re_cfg)) >> 9;
    diffusive = (prod > 128'(LIM_MAX)) ? LIM_MAX : prod[63:0];
    have_adv = 1'b0;
    advective = '0;
    if (pu != 0 && pu < QUALIFY_MAX) begin
      advective = (64'(dx_cfg) << 32) / pu;
      if (advective > LIM_MAX) advective = LIM_MAX;
      have_adv = 1'b1;
    end
    if (pv != 0 && pv < QUALIFY_MAX) begin
      cand = (64'(dy_cfg) << 32) / pv;
      if (cand > LIM_MAX) cand = LIM_MAX;
      if (!have_adv || cand < advective) advective = cand;
      have_adv = 1'b1;
    end
    if (!have_adv) advective = diffusive;
    base = (advective < diffusive) ? advective : diffusive;
    if (base < STEP_MIN) base = STEP_MIN;
    scaled = (base * 64'(cfl_cfg)) >> 16;
    if (scaled < STEP_MIN) scaled = STEP_MIN;
    if (scaled > STEP_MAX) scaled = STEP_MAX;
    return scaled[22:0];
  endfunction

  function automatic logic [47:0] rand_velocity();
    logic [63:0] mag;
    int          bits;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: return 48'd0;
          1: return 48'h7FFF_FFFF_FFFF;
          2: return 48'h8000_0000_0000;
          3: return 48'(QUALIFY_MAX - 64'd1);
          4: return 48'(QUALIFY_MAX);
          default: return 48'hFFFF_FFFF_FFFF;
        endcase
      end
      1: return 48'({$urandom, $urandom});
      default: begin
        bits = $urandom_range(6, 26);
        mag = {$urandom, $urandom} & ((64'd1 << bits) - 64'd1);
        return $urandom_range(0, 1) ? 48'(-mag) : 48'(mag);
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_value(logic [31:0] lo, logic [31:0] hi,
                                             logic [31:0] common_lo, logic [31:0] common_hi);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      default: return $urandom_range(common_hi, common_lo);
    endcase
  endfunction

  function automatic plan_row_t word_row(bit kind, longint vel, bit last);
    plan_row_t row;
    row.kind = ROW_WORD;
    row.idx = cfl_pkg::REG_SPACING_X;
    row.value = '0;
    row.word.kind = kind;
    row.word.velocity = vel[47:0];
    row.word.last = last;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic plan_row_t known_row(bit kind, longint vel, bit last,
                                          longint step, longint u, longint v);
    plan_row_t row;
    row = word_row(kind, vel, last);
    row.typed = 1'b1;
    row.want.time_step = step[22:0];
    row.want.max_abs_u = u[47:0];
    row.want.max_abs_v = v[47:0];
    return row;
  endfunction

  function automatic plan_row_t cfg_row(cfl_pkg::reg_idx_t idx, logic [31:0] value);
    plan_row_t row;
    row = word_row(1'b0, 0, 1'b0);
    row.kind = ROW_CFG;
    row.idx = idx;
    row.value = value;
    return row;
  endfunction

  task automatic push_word(cfl_pkg::in_word_t w, bit typed, cfl_pkg::out_word_t want);
    int                  pct;
    logic [47:0]         raw, mag;
    cfl_pkg::out_word_t  step_word;
    pct = (idle_mode == IDLE_SENDER) ? 63 : (idle_mode == IDLE_BOTH) ? 26 : 0;
    if ($urandom_range(0, 99) < pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < pct);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    raw = w.velocity;
    mag = raw[47] ? (~raw + 48'd1) : raw;
    if (w.kind) begin
      if (64'(mag) > peak_v) peak_v = 64'(mag);
    end else begin
      if (64'(mag) > peak_u) peak_u = 64'(mag);
    end
    if (w.last) begin
      if (typed) begin
        pending_steps.push_back(want);
      end else begin
        step_word.time_step = predict_step(peak_u, peak_v);
        step_word.max_abs_u = peak_u[47:0];
        step_word.max_abs_v = peak_v[47:0];
        pending_steps.push_back(step_word);
      end
      peak_u = '0;
      peak_v = '0;
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(cfl_pkg::reg_idx_t idx, logic [31:0] value);
    logic [31:0] kept;
    kept = (idx == cfl_pkg::REG_SAFETY_FACTOR) ? (value & 32'h3FFFF) : value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      cfl_pkg::REG_SPACING_X: dx_cfg = kept;
      cfl_pkg::REG_SPACING_Y: dy_cfg = kept;
      cfl_pkg::REG_REYNOLDS: re_cfg = kept;
      cfl_pkg::REG_SAFETY_FACTOR: cfl_cfg = kept[17:0];
    endcase
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== kept) note_mismatch("register readback", 64'(kept), 64'(prdata));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (idle_mode == IDLE_RECEIVER) out_ready <= ($urandom_range(0, 99) >= 63);
    else if (idle_mode == IDLE_BOTH) out_ready <= ($urandom_range(0, 99) >= 26);
    else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_steps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result word with nothing expected: time_step %0d", out_data.time_step);
      end else begin
        head = pending_steps.pop_front();
        steps_checked++;
        if (out_data.time_step !== head.time_step)
          note_mismatch("time_step", 64'(head.time_step), 64'(out_data.time_step));
        if (out_data.max_abs_u !== head.max_abs_u)
          note_mismatch("max_abs_u", 64'(head.max_abs_u), 64'(out_data.max_abs_u));
        if (out_data.max_abs_v !== head.max_abs_v)
          note_mismatch("max_abs_v", 64'(head.max_abs_v), 64'(out_data.max_abs_v));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("** cfl_timestep_limiter: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int                  phase_words, run_len;
    bit                  paused;
    cfl_pkg::in_word_t   w;
    cfl_pkg::out_word_t  none;
    none = '0;
    paused = 1'b0;

    plan.push_back(known_row(1'b0, 0, 1'b1, 4294967, 0, 0));
    plan.push_back(known_row(1'b1, -(longint'(1) << 47), 1'b1, 4294967, 0, longint'(1) << 47));
    plan.push_back(known_row(1'b0, (longint'(1) << 47) - 1, 1'b1, 4294967,
                             (longint'(1) << 47) - 1, 0));
    plan.push_back(word_row(1'b0, 1, 1'b0));
    plan.push_back(word_row(1'b1, -1, 1'b1));
    plan.push_back(known_row(1'b0, 64'sd65535999999, 1'b1, 4295, 64'sd65535999999, 0));
    plan.push_back(known_row(1'b1, 64'sd65536000000, 1'b1, 4294967, 0, 64'sd65536000000));
    plan.push_back(word_row(1'b0, -3 * 65536, 1'b0));
    plan.push_back(word_row(1'b1, 7 * 65536, 1'b0));
    plan.push_back(word_row(1'b1, -2 * 65536, 1'b0));
    plan.push_back(word_row(1'b0, 5 * 65536, 1'b1));
    plan.push_back(cfg_row(cfl_pkg::REG_REYNOLDS, 32'd0));
    plan.push_back(known_row(1'b0, 65536, 1'b1, 4295, 65536, 0));
    plan.push_back(cfg_row(cfl_pkg::REG_SAFETY_FACTOR, 32'd0));
    plan.push_back(cfg_row(cfl_pkg::REG_REYNOLDS, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(cfl_pkg::REG_SPACING_X, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(cfl_pkg::REG_SPACING_Y, 32'hFFFF_FFFF));
    plan.push_back(known_row(1'b0, 0, 1'b1, 4295, 0, 0));
    plan.push_back(cfg_row(cfl_pkg::REG_SAFETY_FACTOR, 32'h3FFFF));
    plan.push_back(known_row(1'b1, 1, 1'b1, 4294967, 0, 1));
    plan.push_back(cfg_row(cfl_pkg::REG_SPACING_X, 32'd1));
    plan.push_back(cfg_row(cfl_pkg::REG_SPACING_Y, 32'd1));
    plan.push_back(cfg_row(cfl_pkg::REG_REYNOLDS, 32'd1));
    plan.push_back(word_row(1'b1, 1, 1'b1));
    plan.push_back(word_row(1'b0, -65536, 1'b1));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        cfg_write(plan[i].idx, plan[i].value);
      end else begin
        push_word(plan[i].word, plan[i].typed, plan[i].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      idle_mode = idle_mode_t'(phase % 4);
      if (phase == 0) begin
        cfg_write(cfl_pkg::REG_SPACING_X, 32'hFFFF_FFFF);
        cfg_write(cfl_pkg::REG_SPACING_Y, 32'hFFFF_FFFF);
        cfg_write(cfl_pkg::REG_REYNOLDS, 32'hFFFF_FFFF);
        cfg_write(cfl_pkg::REG_SAFETY_FACTOR, 32'h3FFFF);
      end else begin
        cfg_write(cfl_pkg::REG_SPACING_X,
                  pick_value(32'd1, 32'hFFFF_FFFF, 32'd64, 32'd4096));
        cfg_write(cfl_pkg::REG_SPACING_Y,
                  pick_value(32'd1, 32'hFFFF_FFFF, 32'd64, 32'd4096));
        cfg_write(cfl_pkg::REG_REYNOLDS,
                  pick_value(32'd0, 32'hFFFF_FFFF, 32'd256, 32'd65536));
        cfg_write(cfl_pkg::REG_SAFETY_FACTOR,
                  pick_value(32'd0, 32'h3FFFF, 32'd8192, 32'd131072));
      end
      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        if (phase == 5 && !paused && phase_words >= PHASE_WORDS / 2) begin
          settle();
          paused = 1'b1;
        end
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int k = 0; k < run_len; k++) begin
          w.kind = 1'($urandom_range(0, 1));
          w.velocity = rand_velocity();
          w.last = (k == run_len - 1);
          push_word(w, 1'b0, none);
          phase_words++;
        end
      end
    end

    settle();
    $display("Sent %0d words and checked %0d time steps under the reset setting,", words_sent,
             steps_checked);
    $display("register extremes and %0d further settings, with four idling patterns.", PHASES);
    if (mismatches == 0) begin
      $display("** cfl_timestep_limiter: PASSED **");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("** cfl_timestep_limiter: FAILED **");
    end
    $finish;
  end

endmodule
